[sv/jacobi_laplace_grid_solver_unit_defines.svh]
// assertion macros for the jacobi laplace grid solver
// no dependencies; used by the top level
`ifndef JACOBI_LAPLACE_GRID_SOLVER_UNIT_DEFINES_SVH
`define JACOBI_LAPLACE_GRID_SOLVER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define JLG_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define JLG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define JLG_ASSERT(lbl, prop)
`define JLG_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

[sv/jlg_pkg.sv]
// types and constants for the jacobi laplace grid solver
// no dependencies
`timescale 1ns / 1ps
package jlg_pkg;
    localparam int unsigned C_QW = 28;
    localparam logic [C_QW-1:0] C_Q10_DIVIDEND = 28'd167772160;
    localparam logic [31:0] C_Q10 = 32'd167772160;
    localparam logic [31:0] C_Q20 = 32'd335544320;
    localparam logic [31:0] C_Q30 = 32'd503316480;
    localparam logic [28:0] C_ERR_MAX = 29'h1FFF_FFFF;
    localparam logic [9:0] C_CHK_LAST = 10'd999;
    localparam logic [2:0] C_K_CENTER = 3'd4;
    localparam logic [2:0] C_K_CALC = 3'd5;
    localparam logic [2:0] C_K_WRITE = 3'd6;
    localparam logic [1:0] C_REG_SIDE = 2'd0;
    localparam logic [1:0] C_REG_ACC = 2'd1;
    localparam logic [1:0] C_REG_ITER = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_INIT,
        S_CHECK,
        S_CELL,
        S_SWEEP_END
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;
endpackage

[sv/jlg_ram.sv]
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module jlg_ram #(
    parameter int W = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/jlg_div.sv]
// restoring divider, one quotient bit per cycle, for the edge step
// depends on jlg_pkg
`timescale 1ns / 1ps
module jlg_div #(
    parameter int DW = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [DW-1:0]           i_den,
    output jlg_pkg::t_div_stat      o_stat,
    output logic [jlg_pkg::C_QW-1:0] o_quo,
    output logic [DW-1:0]           o_rem
);
    import jlg_pkg::*;

    logic [C_QW-1:0] r_quo;
    logic [DW-1:0]   r_rem;
    logic [4:0]      r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [DW:0]     w_trial;
    logic            w_ge;

    assign w_trial = {r_rem, r_quo[C_QW-1]};
    assign w_ge = w_trial >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 5'(C_QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= C_Q10_DIVIDEND;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[C_QW-2:0], w_ge};
            r_rem <= w_ge ? DW'(w_trial - {1'b0, i_den}) : DW'(w_trial);
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo = r_quo;
    assign o_rem = r_rem;
endmodule

[sv/jacobi_laplace_grid_solver_unit.sv]
// one run: divider setup, an n*n grid fill, then sweeps over the (n-2)*(n-2)
// interior cells, where n is the clamped side
// five single-port reads per interior cell set the sweep length
// a new start is taken only after the previous result is taken
// synchronous active-low reset clears control and config; grid rams
// are not cleared, every start rewrites them
`timescale 1ns / 1ps
`include "jacobi_laplace_grid_solver_unit_defines.svh"
module jacobi_laplace_grid_solver_unit #(
    parameter int MAX_SIDE = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_start_req,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [19:0] o_sweeps_done,
    output logic [28:0] o_final_error,
    output logic        o_converged,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [28:0] i_cfg_data
);
    import jlg_pkg::*;

    localparam int NW = $clog2(MAX_SIDE + 1);
    localparam int DW = $clog2(MAX_SIDE);
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW = $clog2(DEPTH);

    t_state r_state, n_state;
    logic [8:0]  r_grid_side;
    logic [28:0] r_acc;
    logic [19:0] r_iter;
    logic [NW-1:0] r_n, r_row, r_col, w_n;
    logic [DW-1:0] r_den, r_rc, r_rr;
    logic [27:0] r_qc;
    logic [28:0] r_qr;
    logic [AW-1:0] r_addr;
    logic [19:0] r_sc;
    logic [9:0]  r_chk;
    logic [31:0] r_err, r_mx, r_avg, r_ctr;
    logic        r_measured, r_meas, r_src;
    logic [2:0]  r_k;
    logic signed [34:0] r_sum;
    logic        r_out_valid;
    logic [19:0] r_out_sc;
    logic [28:0] r_out_err;
    logic        r_out_conv;

    t_div_stat   w_div;
    logic [27:0] w_quo;
    logic [DW-1:0] w_rem;
    logic        w_div_start;

    logic        w_we_a, w_we_b;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [31:0] w_wdata, w_rd_a, w_rd_b, w_rdata, w_init_val;
    logic [AW-1:0] w_n_a;
    logic [31:0] w_side32;
    logic        w_in_acc, w_go, w_row_end, w_sweep_end, w_init_end;
    logic [DW:0] w_rc_sum, w_rr_sum, w_r2;
    logic        w_r2_ge;
    logic [28:0] w_q20;
    logic [DW-1:0] w_r20;
    logic signed [34:0] w_sum_p2;
    logic signed [32:0] w_diff;
    logic [32:0] w_abs;

    assign w_in_acc = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign w_side32 = 32'(r_grid_side);
    assign w_n = (w_side32 < 32'd3) ? NW'(3) :
                 (w_side32 > 32'(MAX_SIDE)) ? NW'(MAX_SIDE) : NW'(r_grid_side);
    assign w_n_a = AW'(r_n);

    assign w_go = (!r_measured || (r_err > {3'b0, r_acc})) && (r_sc < r_iter);
    assign w_init_end = (r_row == r_n - NW'(1)) && (r_col == r_n - NW'(1));
    assign w_row_end = r_col == r_n - NW'(2);
    assign w_sweep_end = w_row_end && (r_row == r_n - NW'(2));

    // edge interpolation step, derived from the divider result
    assign w_r2 = {w_rem, 1'b0};
    assign w_r2_ge = w_r2 >= {1'b0, r_den};
    assign w_q20 = {w_quo, 1'b0} + {28'b0, w_r2_ge};
    assign w_r20 = w_r2_ge ? DW'(w_r2 - {1'b0, r_den}) : DW'(w_r2);
    assign w_rc_sum = {1'b0, r_rc} + {1'b0, w_rem};
    assign w_rr_sum = {1'b0, r_rr} + {1'b0, w_r20};

    always_comb begin
        if (r_row == '0) begin
            w_init_val = C_Q10 + 32'(r_qc);
        end else if (r_row == r_n - NW'(1)) begin
            w_init_val = C_Q30 - 32'(r_qc);
        end else if (r_col == '0) begin
            w_init_val = C_Q10 + 32'(r_qr);
        end else if (r_col == r_n - NW'(1)) begin
            w_init_val = C_Q20;
        end else begin
            w_init_val = '0;
        end
    end

    assign w_rdata = r_src ? w_rd_b : w_rd_a;
    assign w_sum_p2 = r_sum + 35'sd2;
    assign w_diff = $signed({r_ctr[31], r_ctr}) - $signed({r_avg[31], r_avg});
    assign w_abs = w_diff[32] ? 33'(-w_diff) : 33'(w_diff);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_start_req) n_state = S_DIV_GO;
            end
            S_DIV_GO: n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (w_div.done) n_state = S_INIT;
            end
            S_INIT: begin
                if (w_init_end) n_state = S_CHECK;
            end
            S_CHECK: n_state = w_go ? S_CELL : S_IDLE;
            S_CELL: begin
                if (r_k == C_K_WRITE && w_sweep_end) n_state = S_SWEEP_END;
            end
            S_SWEEP_END: n_state = S_CHECK;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_div_start = 1'b0;
        w_we_a = 1'b0;
        w_we_b = 1'b0;
        w_waddr = r_addr;
        w_wdata = w_init_val;
        w_raddr = r_addr;
        unique case (r_state)
            S_IDLE: o_in_ready = !r_out_valid;
            S_DIV_GO: w_div_start = 1'b1;
            S_INIT: begin
                w_we_a = 1'b1;
                w_we_b = 1'b1;
            end
            S_CELL: begin
                w_wdata = r_avg;
                if (r_k == C_K_WRITE) begin
                    w_we_a = r_src;
                    w_we_b = !r_src;
                end
                case (r_k)
                    3'd0: w_raddr = r_addr - w_n_a;
                    3'd1: w_raddr = r_addr + w_n_a;
                    3'd2: w_raddr = r_addr - AW'(1);
                    3'd3: w_raddr = r_addr + AW'(1);
                    default: w_raddr = r_addr;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_grid_side <= 9'd256;
            r_acc <= 29'd17;
            r_iter <= 20'd1000000;
            r_out_valid <= 1'b0;
            r_sc <= '0;
            r_err <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    C_REG_SIDE: r_grid_side <= i_cfg_data[8:0];
                    C_REG_ACC: r_acc <= i_cfg_data;
                    C_REG_ITER: r_iter <= i_cfg_data[19:0];
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready) r_out_valid <= 1'b0;
            if (r_state == S_INIT && w_init_end) begin
                r_sc <= '0;
                r_err <= {3'b0, r_acc} + 32'd1;
            end
            if (r_state == S_SWEEP_END) begin
                r_sc <= r_sc + 20'd1;
                if (r_meas) r_err <= r_mx;
            end
            if (r_state == S_CHECK && !w_go) r_out_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_n <= w_n;
                r_den <= DW'(w_n - NW'(1));
            end
            S_DIV_WAIT: begin
                r_row <= '0;
                r_col <= '0;
                r_addr <= '0;
                r_qc <= '0;
                r_rc <= r_den >> 1;
                r_qr <= '0;
                r_rr <= r_den >> 1;
            end
            S_INIT: begin
                r_addr <= r_addr + AW'(1);
                if (r_col == r_n - NW'(1)) begin
                    r_col <= '0;
                    r_row <= r_row + NW'(1);
                    r_qc <= '0;
                    r_rc <= r_den >> 1;
                    if (w_rr_sum >= {1'b0, r_den}) begin
                        r_rr <= DW'(w_rr_sum - {1'b0, r_den});
                        r_qr <= r_qr + w_q20 + 29'd1;
                    end else begin
                        r_rr <= DW'(w_rr_sum);
                        r_qr <= r_qr + w_q20;
                    end
                end else begin
                    r_col <= r_col + NW'(1);
                    if (w_rc_sum >= {1'b0, r_den}) begin
                        r_rc <= DW'(w_rc_sum - {1'b0, r_den});
                        r_qc <= r_qc + w_quo + 28'd1;
                    end else begin
                        r_rc <= DW'(w_rc_sum);
                        r_qc <= r_qc + w_quo;
                    end
                end
                r_measured <= 1'b0;
                r_chk <= '0;
                r_src <= 1'b0;
            end
            S_CHECK: begin
                r_row <= NW'(1);
                r_col <= NW'(1);
                r_addr <= w_n_a + AW'(1);
                r_k <= '0;
                r_mx <= '0;
                r_meas <= r_chk == '0;
                r_out_sc <= r_sc;
                r_out_err <= (r_err > 32'(C_ERR_MAX)) ? C_ERR_MAX : r_err[28:0];
                r_out_conv <= r_err <= {3'b0, r_acc};
            end
            S_CELL: begin
                r_k <= (r_k == C_K_WRITE) ? 3'd0 : r_k + 3'd1;
                if (r_k == 3'd0) begin
                    r_sum <= '0;
                end else if (r_k <= C_K_CENTER) begin
                    r_sum <= r_sum + {{3{w_rdata[31]}}, w_rdata};
                end
                if (r_k == C_K_CALC) begin
                    r_avg <= w_sum_p2[33:2];
                    r_ctr <= w_rdata;
                end
                if (r_k == C_K_WRITE) begin
                    if (w_abs[31:0] > r_mx) r_mx <= w_abs[31:0];
                    if (w_row_end) begin
                        r_col <= NW'(1);
                        r_row <= r_row + NW'(1);
                        r_addr <= r_addr + AW'(3);
                    end else begin
                        r_col <= r_col + NW'(1);
                        r_addr <= r_addr + AW'(1);
                    end
                end
            end
            S_SWEEP_END: begin
                if (r_meas) r_measured <= 1'b1;
                r_chk <= (r_chk == C_CHK_LAST) ? 10'd0 : r_chk + 10'd1;
                r_src <= !r_src;
            end
            default: ;
        endcase
    end

    jlg_div #(.DW(DW)) u_div (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_den(r_den),
        .o_stat(w_div),
        .o_quo(w_quo),
        .o_rem(w_rem)
    );

    jlg_ram #(.W(32), .DEPTH(DEPTH)) u_ram_a (
        .i_clk(i_clk),
        .i_we(w_we_a),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rd_a)
    );

    jlg_ram #(.W(32), .DEPTH(DEPTH)) u_ram_b (
        .i_clk(i_clk),
        .i_we(w_we_b),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rd_b)
    );

    assign o_out_valid = r_out_valid;
    assign o_sweeps_done = r_out_sc;
    assign o_final_error = r_out_err;
    assign o_converged = r_out_conv;

    `JLG_ASSERT_IMP(a_no_take_while_pending, o_out_valid, !o_in_ready)
    `JLG_ASSERT_IMP(a_div_done_in_wait, w_div.done, r_state == S_DIV_WAIT)
    `JLG_ASSERT_IMP(a_one_dest, r_state == S_CELL && r_k == C_K_WRITE, $onehot({w_we_a, w_we_b}))
    `JLG_ASSERT_IMP(a_limit_stop, o_out_valid && !o_converged, o_sweeps_done == r_iter)
endmodule

[test/jlg_checker.sv]
// watches the jacobi laplace grid solver channels and scores each result
// holds its own copy of the config and the solver; depends on jlg_pkg
`timescale 1ns / 1ps
module jlg_checker #(
    parameter int MAX_SIDE = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_start_req,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [19:0] i_sweeps_done,
    input  logic [28:0] i_final_error,
    input  logic        i_converged,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [28:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    import jlg_pkg::*;

    localparam int CHECK_PERIOD = 1000;
    localparam longint Q_ONE = 64'sd16777216;

    typedef struct packed {
        logic [19:0] sweeps;
        logic [28:0] err;
        logic        conv;
    } t_solve_result;

    t_solve_result expected_q[$];
    logic [8:0]  side_r;
    logic [28:0] acc_r;
    logic [19:0] iter_r;
    int          cur_grid[MAX_SIDE*MAX_SIDE];
    int          nxt_grid[MAX_SIDE*MAX_SIDE];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending = expected_q.size();

    function automatic int edge_value(longint a, longint b, longint i, longint den);
        longint num;
        longint q;
        num = (b - a) * i;
        if (num >= 0) q = (num + den / 2) / den;
        else q = -((-num + den / 2) / den);
        return int'(a + q);
    endfunction

    function automatic t_solve_result run_solver();
        int n;
        int k;
        int r;
        int c;
        longint s;
        longint d;
        logic [31:0] mx;
        logic [31:0] ad;
        logic [31:0] err;
        logic [19:0] sweeps;
        bit measured;
        longint tl;
        longint tr;
        longint bl;
        longint br;
        t_solve_result res;
        n = side_r < 3 ? 3 : (side_r > MAX_SIDE ? MAX_SIDE : int'(side_r));
        tl = 10 * Q_ONE;
        tr = 20 * Q_ONE;
        bl = 30 * Q_ONE;
        br = 20 * Q_ONE;
        for (k = 0; k < n * n; k++) begin
            cur_grid[k] = 0;
            nxt_grid[k] = 0;
        end
        cur_grid[0] = int'(tl);
        cur_grid[n-1] = int'(tr);
        cur_grid[n*(n-1)] = int'(bl);
        cur_grid[n*n-1] = int'(br);
        for (k = 1; k < n - 1; k++) begin
            cur_grid[k] = edge_value(tl, tr, k, n - 1);
            cur_grid[n*(n-1)+k] = edge_value(bl, br, k, n - 1);
            cur_grid[n*k] = edge_value(tl, bl, k, n - 1);
            cur_grid[n*k+n-1] = edge_value(tr, br, k, n - 1);
        end
        sweeps = '0;
        err = {3'b000, acc_r} + 32'd1;
        measured = 0;
        while ((!measured || err > {3'b000, acc_r}) && sweeps < iter_r) begin
            for (r = 1; r < n - 1; r++)
                for (c = 1; c < n - 1; c++) begin
                    s = longint'(cur_grid[(r+1)*n+c]) + cur_grid[(r-1)*n+c]
                        + cur_grid[r*n+c-1] + cur_grid[r*n+c+1];
                    nxt_grid[r*n+c] = int'((s + 2) >>> 2);
                end
            if (sweeps % CHECK_PERIOD == 0) begin
                mx = '0;
                for (r = 1; r < n - 1; r++)
                    for (c = 1; c < n - 1; c++) begin
                        d = longint'(cur_grid[r*n+c]) - nxt_grid[r*n+c];
                        ad = (d < 0) ? 32'(-d) : 32'(d);
                        if (ad > mx) mx = ad;
                    end
                err = mx;
                measured = 1;
            end
            for (r = 1; r < n - 1; r++)
                for (c = 1; c < n - 1; c++)
                    cur_grid[r*n+c] = nxt_grid[r*n+c];
            sweeps = sweeps + 20'd1;
        end
        res.sweeps = sweeps;
        res.err = (err > {3'b000, C_ERR_MAX}) ? C_ERR_MAX : err[28:0];
        res.conv = (err <= {3'b000, acc_r});
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_solve_result exp_r;
        if (!i_rst_n) begin
            side_r <= 9'd256;
            acc_r <= 29'd17;
            iter_r <= 20'd1000000;
            fails <= 0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    C_REG_SIDE: side_r <= i_cfg_data[8:0];
                    C_REG_ACC:  acc_r <= i_cfg_data;
                    C_REG_ITER: iter_r <= i_cfg_data[19:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready && i_start_req)
                expected_q.push_back(run_solver());
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    if (fails < 10)
                        $display("unexpected result transaction: sweeps %0d err %0d conv %0d",
                                 i_sweeps_done, i_final_error, i_converged);
                    fails <= fails + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (exp_r.sweeps !== i_sweeps_done || exp_r.err !== i_final_error ||
                        exp_r.conv !== i_converged) begin
                        if (fails < 10)
                            $display({"mismatch: expected sweeps %0d err %0d conv %0d,",
                                      " got %0d %0d %0d"},
                                     exp_r.sweeps, exp_r.err, exp_r.conv,
                                     i_sweeps_done, i_final_error, i_converged);
                        fails <= fails + 1;
                    end
                end
            end
        end
    end
endmodule

[test/tb_top.sv]
// stimulus and verdict for the jacobi laplace grid solver unit
// depends on jlg_pkg, jlg_checker and the solver rtl
`timescale 1ns / 1ps
module tb_top;
    import jlg_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 3000000;
    localparam int TARGET_ITEMS = 100;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_start_req;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [19:0] o_sweeps_done;
    logic [28:0] o_final_error;
    logic        o_converged;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [28:0] i_cfg_data;
    int          fail_count;
    int          pending;
    bit          quiet;
    int          stall_left;
    int          idle_cycles;
    int          items_sent;

    jacobi_laplace_grid_solver_unit dut (.*);

    jlg_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_start_req(i_start_req),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_sweeps_done(o_sweeps_done), .i_final_error(o_final_error),
        .i_converged(o_converged),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        if (!quiet && stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 12);
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [28:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_start(input logic req);
        int gap;
        gap = (!quiet && $urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_start_req = req;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // drop valid, drain every expected result, let the block settle
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [8:0] side, input logic [28:0] acc,
                              input logic [19:0] iter);
        logic [28:0] noise;
        noise = 29'($urandom);
        write_reg(C_REG_SIDE, {noise[28:9], side});
        write_reg(C_REG_ACC, acc);
        noise = 29'($urandom);
        write_reg(C_REG_ITER, {noise[28:20], iter});
    endtask

    initial begin
        logic [8:0]  side;
        logic [28:0] acc;
        logic [19:0] iter;
        int          count;
        quiet = 0;
        stall_left = 0;
        idle_cycles = 0;
        items_sent = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_start_req = 1'b0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = C_REG_SIDE;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero iteration limit, side clamped up, no-request transaction
        set_config(9'd0, 29'd0, 20'd0);
        write_reg(REG_UNUSED, 29'h1FFF_FFFF);
        send_start(1'b0);
        send_start(1'b1);
        send_start(1'b0);
        drain_results();
        // loose accuracy with the largest iteration limit
        set_config(9'd3, 29'h1FFF_FFFF, 20'hFFFFF);
        send_start(1'b1);
        send_start(1'b1);
        drain_results();
        // tight accuracy, converges on a later check
        set_config(9'd3, 29'd0, 20'd1000000);
        send_start(1'b1);
        drain_results();
        set_config(9'd4, 29'd17, 20'd1001);
        send_start(1'b1);
        drain_results();
        set_config(9'd2, 29'd100, 20'd7);
        send_start(1'b1);
        drain_results();
        // side clamped down to the largest grid
        set_config(9'd511, 29'd0, 20'd1);
        send_start(1'b1);
        drain_results();
        set_config(9'd5, 29'd1 << 28, 20'd3);
        send_start(1'b1);
        drain_results();

        while (items_sent < TARGET_ITEMS) begin
            if (items_sent > TARGET_ITEMS * 4 / 5) quiet = 1;
            case ($urandom_range(0, 9))
                0, 1: side = 9'($urandom_range(0, 2));
                2:    side = 9'($urandom_range(6, 8));
                default: side = 9'($urandom_range(3, 5));
            endcase
            case ($urandom_range(0, 3))
                0: acc = 29'($urandom_range(0, 100));
                1: acc = 29'($urandom);
                2: acc = 29'($urandom_range(300000000, 340000000));
                default: acc = 29'($urandom_range(0, 1 << 20));
            endcase
            if (side <= 3 && $urandom_range(0, 5) == 0)
                iter = 20'($urandom_range(900, 1100));
            else
                iter = 20'($urandom_range(0, 40));
            set_config(side, acc, iter);
            if ($urandom_range(0, 4) == 0)
                write_reg(REG_UNUSED, 29'($urandom));
            count = $urandom_range(1, 4);
            repeat (count) send_start($urandom_range(0, 7) != 0);
            drain_results();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
